// File: src/ptsd_pkg.sv
// shared types, widths and latencies of the point to triangle distance unit
`default_nettype none
package ptsd_pkg;

  localparam int CoordBits = 20;
  localparam int FracBits  = 8;
  localparam int DistBits  = 50;

  localparam int DiffW    = CoordBits + 1;
  localparam int SprodW   = 2 * DiffW;
  localparam int DotW     = SprodW + 2;
  localparam int NrmW     = SprodW + 1;
  localparam int EuW      = DotW + 1;
  localparam int MulW     = 3 * CoordBits + 8;
  localparam int MulLimbW = 17;
  localparam int MulLimbs = (MulW + MulLimbW - 1) / MulLimbW;
  localparam int PadW     = MulLimbs * MulLimbW;
  localparam int ProdW    = 2 * MulW;
  localparam int DenW     = 2 * NrmW + 2;
  localparam int NumW     = ProdW + FracBits;

  localparam int FrontLat = 3;
  localparam int MulLat   = 5;
  localparam int DivLat   = DistBits + 2;
  localparam int TotalLat = FrontLat + MulLat + 2 + MulLat + 1 + DivLat;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffW-1:0]     diff_t;
  typedef logic signed [SprodW-1:0]    sprod_t;
  typedef logic signed [DotW-1:0]      dot_t;
  typedef logic signed [NrmW-1:0]      nrm_t;
  typedef logic signed [MulW-1:0]      mop_t;
  typedef logic signed [ProdW-1:0]     prod_t;

  typedef enum logic [2:0] {
    RegVertA  = 3'd0,
    RegVertB  = 3'd1,
    RegEdgeAB = 3'd2,
    RegVertC  = 3'd3,
    RegEdgeAC = 3'd4,
    RegEdgeBC = 3'd5,
    RegInside = 3'd6
  } region_e;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } item_t;

  typedef struct packed {
    logic [DistBits-1:0] dist_squared;
    logic [2:0]          region;
    logic                degenerate;
  } result_t;

  // edge/point dot products, squared lengths, the normal and the point offset from a
  typedef struct {
    nrm_t  nrm [3];
    dot_t  e   [6];
    dot_t  sq  [3];
    dot_t  len [3];
    diff_t rpa [3];
  } front_t;

endpackage
`default_nettype wire

// File: src/ptsd_front.sv
// front stages: differences, small products and dot product sums
`default_nettype none
module ptsd_front import ptsd_pkg::*; (
  input  logic   clk_i,
  input  item_t  item_i,
  output front_t front_o
);

  coord_t p [3];
  coord_t a [3];
  coord_t b [3];
  coord_t c [3];

  diff_t eab_d [3], eac_d [3], ebc_d [3], rpa_d [3], rpb_d [3], rpc_d [3];
  diff_t eab_q [3], eac_q [3], ebc_q [3], rpa_q [3], rpb_q [3], rpc_q [3];

  sprod_t pe_d [6][3], pe_q [6][3];
  sprod_t sqp_d [3][3], sqp_q [3][3];
  sprod_t lenp_d [3][3], lenp_q [3][3];
  sprod_t np_d [6], np_q [6];
  diff_t  rpa2_d [3], rpa2_q [3];

  front_t f_d, f_q;

  function automatic sprod_t smul(diff_t x, diff_t y);
    return SprodW'(x) * SprodW'(y);
  endfunction

  // stage 1: vertex and point differences
  always_comb begin
    p[0] = item_i.point_x; p[1] = item_i.point_y; p[2] = item_i.point_z;
    a[0] = item_i.a_x;     a[1] = item_i.a_y;     a[2] = item_i.a_z;
    b[0] = item_i.b_x;     b[1] = item_i.b_y;     b[2] = item_i.b_z;
    c[0] = item_i.c_x;     c[1] = item_i.c_y;     c[2] = item_i.c_z;
    for (int i = 0; i < 3; i++) begin
      eab_d[i] = DiffW'(b[i]) - DiffW'(a[i]);
      eac_d[i] = DiffW'(c[i]) - DiffW'(a[i]);
      ebc_d[i] = DiffW'(c[i]) - DiffW'(b[i]);
      rpa_d[i] = DiffW'(p[i]) - DiffW'(a[i]);
      rpb_d[i] = DiffW'(p[i]) - DiffW'(b[i]);
      rpc_d[i] = DiffW'(p[i]) - DiffW'(c[i]);
    end
  end

  // stage 2: per-component products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pe_d[0][i]   = smul(eab_q[i], rpa_q[i]);
      pe_d[1][i]   = smul(eac_q[i], rpa_q[i]);
      pe_d[2][i]   = smul(eab_q[i], rpb_q[i]);
      pe_d[3][i]   = smul(eac_q[i], rpb_q[i]);
      pe_d[4][i]   = smul(eab_q[i], rpc_q[i]);
      pe_d[5][i]   = smul(eac_q[i], rpc_q[i]);
      sqp_d[0][i]  = smul(rpa_q[i], rpa_q[i]);
      sqp_d[1][i]  = smul(rpb_q[i], rpb_q[i]);
      sqp_d[2][i]  = smul(rpc_q[i], rpc_q[i]);
      lenp_d[0][i] = smul(eab_q[i], eab_q[i]);
      lenp_d[1][i] = smul(eac_q[i], eac_q[i]);
      lenp_d[2][i] = smul(ebc_q[i], ebc_q[i]);
      rpa2_d[i]    = rpa_q[i];
    end
    np_d[0] = smul(eab_q[1], eac_q[2]);
    np_d[1] = smul(eab_q[2], eac_q[1]);
    np_d[2] = smul(eab_q[2], eac_q[0]);
    np_d[3] = smul(eab_q[0], eac_q[2]);
    np_d[4] = smul(eab_q[0], eac_q[1]);
    np_d[5] = smul(eab_q[1], eac_q[0]);
  end

  // stage 3: sums
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      f_d.e[k] = DotW'(pe_q[k][0]) + DotW'(pe_q[k][1]) + DotW'(pe_q[k][2]);
    end
    for (int k = 0; k < 3; k++) begin
      f_d.sq[k]  = DotW'(sqp_q[k][0]) + DotW'(sqp_q[k][1]) + DotW'(sqp_q[k][2]);
      f_d.len[k] = DotW'(lenp_q[k][0]) + DotW'(lenp_q[k][1]) + DotW'(lenp_q[k][2]);
      f_d.nrm[k] = NrmW'(np_q[2*k]) - NrmW'(np_q[2*k+1]);
      f_d.rpa[k] = rpa2_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    eab_q  <= eab_d;
    eac_q  <= eac_d;
    ebc_q  <= ebc_d;
    rpa_q  <= rpa_d;
    rpb_q  <= rpb_d;
    rpc_q  <= rpc_d;
    pe_q   <= pe_d;
    sqp_q  <= sqp_d;
    lenp_q <= lenp_d;
    np_q   <= np_d;
    rpa2_q <= rpa2_d;
    f_q    <= f_d;
  end

  assign front_o = f_q;

endmodule
`default_nettype wire

// File: src/ptsd_mul.sv
// pipelined wide signed multiplier built from limb partial products
`default_nettype none
module ptsd_mul import ptsd_pkg::*; (
  input  logic  clk_i,
  input  mop_t  a_i,
  input  mop_t  b_i,
  output prod_t p_o
);

  logic [PadW-1:0]         ma_d, mb_d, ma_q, mb_q;
  logic [MulLat-2:0]       neg_q;
  logic [2*MulLimbW-1:0]   pp_d [MulLimbs][MulLimbs];
  logic [2*MulLimbW-1:0]   pp_q [MulLimbs][MulLimbs];
  logic [ProdW-1:0]        row_d [MulLimbs];
  logic [ProdW-1:0]        row_q [MulLimbs];
  logic [ProdW-1:0]        sum_d, sum_q;
  prod_t                   p_d, p_q;

  // magnitudes, sign kept aside
  always_comb begin
    ma_d = PadW'($unsigned(a_i[MulW-1] ? -a_i : a_i));
    mb_d = PadW'($unsigned(b_i[MulW-1] ? -b_i : b_i));
  end

  always_comb begin
    for (int i = 0; i < MulLimbs; i++) begin
      for (int j = 0; j < MulLimbs; j++) begin
        pp_d[i][j] = (2*MulLimbW)'(ma_q[i*MulLimbW +: MulLimbW]) *
                     (2*MulLimbW)'(mb_q[j*MulLimbW +: MulLimbW]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MulLimbs; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < MulLimbs; j++) begin
        row_d[i] = row_d[i] + (ProdW'(pp_q[i][j]) << (MulLimbW * j));
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < MulLimbs; i++) begin
      sum_d = sum_d + (row_q[i] << (MulLimbW * i));
    end
    p_d = neg_q[MulLat-2] ? -$signed(sum_q) : $signed(sum_q);
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    neg_q <= {neg_q[MulLat-3:0], a_i[MulW-1] ^ b_i[MulW-1]};
    pp_q  <= pp_d;
    row_q <= row_d;
    sum_q <= sum_d;
    p_q   <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: src/ptsd_div.sv
// pipelined restoring divider, one quotient bit per stage, with saturation
`default_nettype none
module ptsd_div import ptsd_pkg::*; (
  input  logic                clk_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output logic [DistBits-1:0] quo_o
);

  logic [NumW-1:0]     rem_q [DistBits+1];
  logic [DenW-1:0]     den_q [DistBits+1];
  logic [DistBits-1:0] quo_q [DistBits+1];
  logic                sat_q [DistBits+1];
  logic [DistBits-1:0] out_d, out_q;

  // quotient too wide for the result when num >= den * 2^DistBits
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    sat_q[0] <= (num_i >> DistBits) >= NumW'(den_i);
  end

  for (genvar s = 0; s < DistBits; s++) begin : g_step
    localparam int K = DistBits - 1 - s;
    localparam logic [NumW-1:0] LowMask = (NumW'(1) << K) - NumW'(1);
    logic [NumW-1:0] hi;
    logic [NumW-1:0] rem_d;
    logic            take;

    always_comb begin
      hi    = rem_q[s] >> K;
      take  = hi >= NumW'(den_q[s]);
      rem_d = take ? (((hi - NumW'(den_q[s])) << K) | (rem_q[s] & LowMask)) : rem_q[s];
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      den_q[s+1] <= den_q[s];
      quo_q[s+1] <= {quo_q[s][DistBits-2:0], take};
      sat_q[s+1] <= sat_q[s];
    end
  end

  assign out_d = sat_q[DistBits] ? '1 : quo_q[DistBits];

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign quo_o = out_q;

endmodule
`default_nettype wire

// File: src/point_triangle_squared_distance_unit.sv
// top level: squared distance from a point to a triangle with region code
//
//  channel  | signals              | direction | meaning
//  ---------+----------------------+-----------+------------------------------------
//  command  | start, busy, item_i  | in/out    | point and three vertices, one item
//  result   | done_o, result_o     | out       | floor(256 * dist^2), region, flag
//
// every item runs through the front, both multiplier passes and the divider
// to its done_o strobe; one item may enter every cycle, busy stays low
// the latency is set by the divider, one quotient bit per stage (50 stages plus
// the saturation check and the output register), and by two passes through the
// five-stage limb multiplier
// reset clears only the valid chain; data registers hold whatever they had
// results cannot be held off, so the pipeline never stalls
`default_nettype none
module point_triangle_squared_distance_unit import ptsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  typedef struct {
    dot_t e   [6];
    dot_t sq  [3];
    dot_t len [3];
    logic degen;
  } side_t;

  typedef struct packed {
    region_e         region;
    logic [DenW-1:0] den;
    logic            degen;
  } side2_t;

  typedef struct packed {
    region_e region;
    logic    degen;
  } side3_t;

  // valid chain, one bit per register stage
  logic [TotalLat-1:0] valid_q;

  front_t fr;
  side_t  s1_d;
  side_t  s1_q [MulLat];

  // first multiplier pass: cross tests, plane offset, normal length
  mop_t  ma_a [12];
  mop_t  ma_b [12];
  prod_t pa   [12];

  logic            xle_d [3], xle_q [3];
  mop_t            h_d, h_q;
  logic [DenW-1:0] nn_d, nn_q;
  side_t           sj_q;

  // region choice and operands of the second pass
  region_e         reg_d, reg_q;
  mop_t            opa_d, opb_d, opc_d, opd_d;
  mop_t            opa_q, opb_q, opc_q, opd_q;
  logic [DenW-1:0] den_d, den_q;
  logic            dgn_q;
  logic signed [EuW-1:0] eu_bc;

  prod_t  pb [2];
  side2_t s2_q [MulLat];

  prod_t           num_s;
  logic [NumW-1:0] nnum_d, nnum_q;
  side2_t          sn_q;
  side3_t          s3_q [DivLat];
  logic [DistBits-1:0] quo;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[TotalLat-2:0], start & ~busy};
    end
  end

  ptsd_front u_front (
    .clk_i   (clk_i),
    .item_i  (item_i),
    .front_o (fr)
  );

  // normal of zero length means collinear or coincident vertices
  always_comb begin
    s1_d.e     = fr.e;
    s1_d.sq    = fr.sq;
    s1_d.len   = fr.len;
    s1_d.degen = (fr.nrm[0] == '0) && (fr.nrm[1] == '0) && (fr.nrm[2] == '0);
  end

  always_comb begin
    ma_a[0] = MulW'(fr.e[0]); ma_b[0] = MulW'(fr.e[3]);
    ma_a[1] = MulW'(fr.e[2]); ma_b[1] = MulW'(fr.e[1]);
    ma_a[2] = MulW'(fr.e[4]); ma_b[2] = MulW'(fr.e[1]);
    ma_a[3] = MulW'(fr.e[0]); ma_b[3] = MulW'(fr.e[5]);
    ma_a[4] = MulW'(fr.e[2]); ma_b[4] = MulW'(fr.e[5]);
    ma_a[5] = MulW'(fr.e[4]); ma_b[5] = MulW'(fr.e[3]);
    for (int i = 0; i < 3; i++) begin
      ma_a[6+i] = MulW'(fr.rpa[i]); ma_b[6+i] = MulW'(fr.nrm[i]);
      ma_a[9+i] = MulW'(fr.nrm[i]); ma_b[9+i] = MulW'(fr.nrm[i]);
    end
  end

  for (genvar m = 0; m < 12; m++) begin : g_mul_a
    ptsd_mul u_mul (
      .clk_i (clk_i),
      .a_i   (ma_a[m]),
      .b_i   (ma_b[m]),
      .p_o   (pa[m])
    );
  end

  always_ff @(posedge clk_i) begin
    s1_q[0] <= s1_d;
    for (int i = 1; i < MulLat; i++) begin
      s1_q[i] <= s1_q[i-1];
    end
  end

  // cross test signs, offset from the plane, squared normal length
  always_comb begin
    xle_d[0] = pa[0] <= pa[1];
    xle_d[1] = pa[2] <= pa[3];
    xle_d[2] = pa[4] <= pa[5];
    h_d      = MulW'(pa[6] + pa[7] + pa[8]);
    nn_d     = DenW'(pa[9] + pa[10] + pa[11]);
  end

  always_ff @(posedge clk_i) begin
    xle_q <= xle_d;
    h_q   <= h_d;
    nn_q  <= nn_d;
    sj_q  <= s1_q[MulLat-1];
  end

  // region tests in fixed order, first hit wins
  always_comb begin
    eu_bc = EuW'(sj_q.e[3]) - EuW'(sj_q.e[2]);
    reg_d = RegInside;
    opa_d = h_q;
    opb_d = h_q;
    opc_d = '0;
    opd_d = '0;
    den_d = nn_q;
    if (sj_q.degen) begin
      reg_d = RegVertA;
      opa_d = '0;
      opb_d = '0;
      den_d = DenW'(1);
    end else if (sj_q.e[0] <= 0 && sj_q.e[1] <= 0) begin
      reg_d = RegVertA;
      opa_d = MulW'(sj_q.sq[0]);
      opb_d = MulW'(1);
      den_d = DenW'(1);
    end else if (sj_q.e[2] >= 0 && sj_q.e[3] <= sj_q.e[2]) begin
      reg_d = RegVertB;
      opa_d = MulW'(sj_q.sq[1]);
      opb_d = MulW'(1);
      den_d = DenW'(1);
    end else if (xle_q[0] && sj_q.e[0] >= 0 && sj_q.e[2] <= 0) begin
      reg_d = RegEdgeAB;
      opa_d = MulW'(sj_q.sq[0]);
      opb_d = MulW'(sj_q.len[0]);
      opc_d = MulW'(sj_q.e[0]);
      opd_d = MulW'(sj_q.e[0]);
      den_d = DenW'(sj_q.len[0]);
    end else if (sj_q.e[5] >= 0 && sj_q.e[4] <= sj_q.e[5]) begin
      reg_d = RegVertC;
      opa_d = MulW'(sj_q.sq[2]);
      opb_d = MulW'(1);
      den_d = DenW'(1);
    end else if (xle_q[1] && sj_q.e[1] >= 0 && sj_q.e[5] <= 0) begin
      reg_d = RegEdgeAC;
      opa_d = MulW'(sj_q.sq[0]);
      opb_d = MulW'(sj_q.len[1]);
      opc_d = MulW'(sj_q.e[1]);
      opd_d = MulW'(sj_q.e[1]);
      den_d = DenW'(sj_q.len[1]);
    end else if (xle_q[2] && sj_q.e[3] >= sj_q.e[2] && sj_q.e[4] >= sj_q.e[5]) begin
      reg_d = RegEdgeBC;
      opa_d = MulW'(sj_q.sq[1]);
      opb_d = MulW'(sj_q.len[2]);
      opc_d = MulW'(eu_bc);
      opd_d = MulW'(eu_bc);
      den_d = DenW'(sj_q.len[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    reg_q <= reg_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    opc_q <= opc_d;
    opd_q <= opd_d;
    den_q <= den_d;
    dgn_q <= sj_q.degen;
  end

  ptsd_mul u_mul_p (
    .clk_i (clk_i),
    .a_i   (opa_q),
    .b_i   (opb_q),
    .p_o   (pb[0])
  );

  ptsd_mul u_mul_q (
    .clk_i (clk_i),
    .a_i   (opc_q),
    .b_i   (opd_q),
    .p_o   (pb[1])
  );

  always_ff @(posedge clk_i) begin
    s2_q[0] <= '{region: reg_q, den: den_q, degen: dgn_q};
    for (int i = 1; i < MulLat; i++) begin
      s2_q[i] <= s2_q[i-1];
    end
  end

  // numerator, clamped at zero, scaled by the fraction bits
  always_comb begin
    num_s  = pb[0] - pb[1];
    nnum_d = num_s[ProdW-1] ? '0 : (NumW'($unsigned(num_s)) << FracBits);
  end

  always_ff @(posedge clk_i) begin
    nnum_q <= nnum_d;
    sn_q   <= s2_q[MulLat-1];
  end

  ptsd_div u_div (
    .clk_i (clk_i),
    .num_i (nnum_q),
    .den_i (sn_q.den),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i) begin
    s3_q[0] <= '{region: sn_q.region, degen: sn_q.degen};
    for (int i = 1; i < DivLat; i++) begin
      s3_q[i] <= s3_q[i-1];
    end
  end

  assign done_o                = valid_q[TotalLat-1];
  assign result_o.dist_squared = quo;
  assign result_o.region       = s3_q[DivLat-1].region;
  assign result_o.degenerate   = s3_q[DivLat-1].degen;

endmodule
`default_nettype wire
